/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

  // store depth and derived widths
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 16;
  localparam int PAY_W    = 16;
  localparam int COUNT_W  = 7;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // one stored entry
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic   fire;
    logic   pop;
    entry_t item;
  } cell_ctrl_t;

  typedef struct packed {
    cmd_e                    command;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } in_t;

  typedef struct packed {
    status_e                 status;
    logic signed [KEY_W-1:0] out_key;
    logic [PAY_W-1:0]        out_payload;
    logic [COUNT_W-1:0]      count;
  } out_t;

endpackage

/* rtl/sorted_priority_queue_top.sv */
// Sorted priority queue, largest key first, held in a row of CAPACITY cells.
// Input channel in_valid/in_ready/in_data carries one command per beat:
// insert (key, payload) or pop. Output channel out_valid/out_ready/out_data
// returns exactly one result beat per command: status, key, payload and the
// entry count after the command.
// Each command is broadcast to all cells: each compares the key with its own
// entry and moves in step with its neighbors, so a new command is taken
// every cycle while in_ready is high. The result is registered and appears
// in the cycle after its command beat is taken.
// Equal keys leave in arrival order. On a full store an insert whose key
// beats the smallest entry evicts it; otherwise the new entry is returned.
// Both come back with the overflow status.
// Reset clears the count and the output valid; the store is empty at once.
// A stalled receiver holds the result register, and in_ready drops until
// the waiting result beat is taken.
`timescale 1ns / 1ps

module sorted_priority_queue_top import spq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  cell_ctrl_t       ctrl;
  logic             fire;
  logic             full;
  logic             empty;
  logic             is_pop;
  entry_t           cells [CAPACITY];
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] occ;
  out_t             result;

  // handshake
  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign is_pop   = (in_data.command == CMD_POP);
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);

  // broadcast to the chain
  assign ctrl.fire         = fire;
  assign ctrl.pop          = is_pop;
  assign ctrl.item.key     = in_data.key;
  assign ctrl.item.payload = in_data.payload;

  // chain of cells
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      assign occ[i] = (count > CNT_W'(i));
      if (i == 0) begin : g_head
        spq_cell u_cell (
          .clk     (clk),
          .ctrl    (ctrl),
          .occ     (occ[i]),
          .ge_left (1'b1),
          .left    (ctrl.item),
          .right   (cells[i+1]),
          .ge      (ge[i]),
          .entry   (cells[i])
        );
      end else if (i == CAPACITY - 1) begin : g_tail
        spq_cell u_cell (
          .clk     (clk),
          .ctrl    (ctrl),
          .occ     (occ[i]),
          .ge_left (ge[i-1]),
          .left    (cells[i-1]),
          .right   ('0),
          .ge      (ge[i]),
          .entry   (cells[i])
        );
      end else begin : g_mid
        spq_cell u_cell (
          .clk     (clk),
          .ctrl    (ctrl),
          .occ     (occ[i]),
          .ge_left (ge[i-1]),
          .left    (cells[i-1]),
          .right   (cells[i+1]),
          .ge      (ge[i]),
          .entry   (cells[i])
        );
      end
    end
  endgenerate

  // next count and result beat
  always_comb begin
    count_next         = count;
    result.status      = ST_INSERTED;
    result.out_key     = '0;
    result.out_payload = '0;
    if (is_pop) begin
      if (empty) begin
        result.status = ST_EMPTY;
      end else begin
        result.status      = ST_POPPED;
        result.out_key     = cells[0].key;
        result.out_payload = cells[0].payload;
        count_next         = count - CNT_W'(1);
      end
    end else if (!full) begin
      count_next = count + CNT_W'(1);
    end else begin
      result.status = ST_OVERFLOW;
      if (ge[CAPACITY-1]) begin
        result.out_key     = in_data.key;
        result.out_payload = in_data.payload;
      end else begin
        result.out_key     = cells[CAPACITY-1].key;
        result.out_payload = cells[CAPACITY-1].payload;
      end
    end
    result.count = COUNT_W'(count_next);
  end

  // count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        count <= count_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

endmodule

/* rtl/spq_cell.sv */
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occ,
  input  logic       ge_left,
  input  entry_t     left,
  input  entry_t     right,
  output logic       ge,
  output entry_t     entry
);

  // this slot stays ahead of the new entry
  assign ge = occ && (entry.key >= ctrl.item.key);

  // shift toward the head on pop, open a gap on insert
  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      if (ctrl.pop) begin
        entry <= right;
      end else if (!ge) begin
        entry <= ge_left ? ctrl.item : left;
      end
    end
  end

endmodule
